// ===== rtl/core/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int BLK_IDX_W  = WORD_IDX_W + BIT_IDX_W;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 21;
  localparam int COUNT_W    = 11;
  localparam int WORDS_W    = COUNT_W - BIT_IDX_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = $clog2(ADDR_W);
  localparam int PROD_W     = BLK_IDX_W + SIZE_W;

  localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(64);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_PICK,
    S_A_READ,
    S_A_MUL,
    S_A_ADD,
    S_F_CHECK,
    S_F_DIV,
    S_F_RANGE,
    S_F_READ,
    S_F_DONE
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  block_address;
    logic [COUNT_W-1:0] used_count;
  } rsp_t;

  typedef struct packed {
    logic    load_req;
    logic    div_init;
    logic    div_step;
    logic    rd_alloc;
    logic    rd_free;
    logic    alloc_commit;
    logic    free_commit;
    logic    mul;
    logic    emit;
    logic    emit_addr;
    status_t emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic alloc_full;
    logic below_base;
    logic div_last;
    logic out_of_range;
    logic bit_set;
  } dp_stat_t;

endpackage

// ===== rtl/core/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps

// Channel    Ports                             Transaction
// request    start, busy, request              accepted when start && !busy
// result     done, result                      one cycle, marked by done
// config     cfg_we, cfg_index, cfg_data       written when cfg_we is high
//
// Allocate: S_A_PICK, S_A_READ, S_A_MUL, S_A_ADD; only S_A_PICK when full.
// Free: S_F_CHECK, the 32-step serial divider, S_F_RANGE, S_F_READ and
// S_F_DONE, stopping at S_F_CHECK below base and S_F_RANGE past the blocks.
// Synchronous reset clears the map at once through per-word valid flags.
// Results cannot be stalled; write configuration only while idle.
module bitmap_block_allocator import bba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  request,
  output logic                  done,
  output rsp_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (request.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bba_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a transaction is still in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STAT_OK) |-> (result.block_address == '0))
    else $error("failed transaction carries an address");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.used_count <= COUNT_W'(MAX_BLOCKS)))
    else $error("used count exceeds capacity");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.alloc_commit, cmd.free_commit, cmd.emit}))
    else $error("map update and result emit overlap");

endmodule

// ===== rtl/core/bba_ctrl.sv =====
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     kind,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (kind == KIND_FREE) ? S_F_CHECK : S_A_PICK;
        end
      end
      S_A_PICK:  state_next = stat.alloc_full ? S_IDLE : S_A_READ;
      S_A_READ:  state_next = S_A_MUL;
      S_A_MUL:   state_next = S_A_ADD;
      S_A_ADD:   state_next = S_IDLE;
      S_F_CHECK: state_next = stat.below_base ? S_IDLE : S_F_DIV;
      S_F_DIV: begin
        if (stat.div_last) begin
          state_next = S_F_RANGE;
        end
      end
      S_F_RANGE: state_next = stat.out_of_range ? S_IDLE : S_F_READ;
      S_F_READ:  state_next = stat.bit_set ? S_F_DONE : S_IDLE;
      S_F_DONE:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit_status = STAT_OK;
    unique case (state)
      S_IDLE: begin
        cmd.load_req = start;
      end
      S_A_PICK: begin
        if (stat.alloc_full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STAT_FULL;
        end else begin
          cmd.rd_alloc = 1'b1;
        end
      end
      S_A_READ: begin
        cmd.alloc_commit = 1'b1;
      end
      S_A_MUL: begin
        cmd.mul = 1'b1;
      end
      S_A_ADD: begin
        cmd.emit      = 1'b1;
        cmd.emit_addr = 1'b1;
      end
      S_F_CHECK: begin
        if (stat.below_base) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STAT_RANGE;
        end else begin
          cmd.div_init = 1'b1;
        end
      end
      S_F_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_F_RANGE: begin
        if (stat.out_of_range) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STAT_RANGE;
        end else begin
          cmd.rd_free = 1'b1;
        end
      end
      S_F_READ: begin
        if (stat.bit_set) begin
          cmd.free_commit = 1'b1;
        end else begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STAT_NOT_ALLOC;
        end
      end
      S_F_DONE: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/core/bba_datapath.sv =====
`timescale 1ns / 1ps

module bba_datapath import bba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  request,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  done,
  output rsp_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [WORD_IDX_W-1:0] lowest_word(input logic [MAP_WORDS-1:0] v);
    logic [WORD_IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (v[i]) idx = WORD_IDX_W'(i);
    end
    return idx;
  endfunction

  // configuration registers
  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  block_size;
  logic [COUNT_W-1:0] block_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RESET;
      block_size   <= SIZE_RESET;
      block_count  <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:  base_address <= cfg_data[ADDR_W-1:0];
        REG_SIZE:  block_size   <= cfg_data[SIZE_W-1:0];
        REG_COUNT: block_count  <= cfg_data[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  logic [SIZE_W-1:0]  stride;
  logic [COUNT_W-1:0] capped;
  logic [COUNT_W-1:0] blocks;
  logic [WORDS_W-1:0] words;

  assign stride = (block_size == '0) ? SIZE_W'(1) : block_size;
  assign capped = (block_count > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : block_count;
  assign words  = capped[COUNT_W-1:BIT_IDX_W];
  assign blocks = {words, {BIT_IDX_W{1'b0}}};

  // request and occupancy count
  logic [ADDR_W-1:0]  addr_q;
  logic [COUNT_W-1:0] used_blocks;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      addr_q <= request.address;
    end
  end

  // occupancy map: memory plus per-word valid and all-ones flags
  logic [WORD_BITS-1:0]  map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]  word_valid;
  logic [MAP_WORDS-1:0]  word_full;
  logic [WORD_BITS-1:0]  rd_data;
  logic                  rd_valid;
  logic [WORD_IDX_W-1:0] word_sel;
  logic [WORD_IDX_W-1:0] rd_addr;
  logic                  rd_en;
  logic [WORD_BITS-1:0]  map_word;
  logic [WORD_BITS-1:0]  wr_data;
  logic                  wr_en;

  logic [MAP_WORDS-1:0]  word_mask;
  logic [MAP_WORDS-1:0]  open_words;
  logic [BIT_IDX_W-1:0]  free_bit;

  // divider
  logic [ADDR_W-1:0]    dvd;
  logic [SIZE_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SIZE_W:0]      trial;

  always_comb begin
    for (int i = 0; i < MAP_WORDS; i++) begin
      word_mask[i] = (WORDS_W'(i) < words);
    end
  end

  assign open_words = ~word_full & word_mask;
  assign rd_en      = cmd.rd_alloc | cmd.rd_free;
  assign rd_addr    = cmd.rd_alloc ? lowest_word(open_words)
                                   : dvd[BLK_IDX_W-1:BIT_IDX_W];
  assign map_word   = rd_valid ? rd_data : '0;
  assign free_bit   = lowest_bit(~map_word);
  assign wr_en      = cmd.alloc_commit | cmd.free_commit;

  always_comb begin
    if (cmd.alloc_commit) begin
      wr_data = map_word | (WORD_BITS'(1) << free_bit);
    end else begin
      wr_data = map_word & ~(WORD_BITS'(1) << dvd[BIT_IDX_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= map_mem[rd_addr];
      word_sel <= rd_addr;
    end
    if (wr_en) begin
      map_mem[word_sel] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid  <= '0;
      word_full   <= '0;
      rd_valid    <= 1'b0;
      used_blocks <= '0;
    end else begin
      if (rd_en) begin
        rd_valid <= word_valid[rd_addr];
      end
      if (cmd.alloc_commit) begin
        word_valid[word_sel] <= 1'b1;
        word_full[word_sel]  <= &wr_data;
        used_blocks          <= used_blocks + COUNT_W'(1);
      end else if (cmd.free_commit) begin
        word_valid[word_sel] <= 1'b1;
        word_full[word_sel]  <= 1'b0;
        if (used_blocks != '0) begin
          used_blocks <= used_blocks - COUNT_W'(1);
        end
      end
    end
  end

  // allocated address: register the index, then the product, then add base
  logic [BLK_IDX_W-1:0] blk_idx;
  logic [PROD_W-1:0]    prod;
  logic [ADDR_W-1:0]    alloc_addr;

  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      blk_idx <= {word_sel, free_bit};
    end
    if (cmd.mul) begin
      prod <= PROD_W'(blk_idx) * PROD_W'(stride);
    end
  end

  assign alloc_addr = base_address + ADDR_W'(prod);

  // restoring divider, one quotient bit a cycle; dvd ends as the quotient
  assign trial = {rem, dvd[ADDR_W-1]} - {1'b0, stride};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd     <= addr_q - base_address;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[SIZE_W]) begin
        rem <= trial[SIZE_W-1:0];
        dvd <= {dvd[ADDR_W-2:0], 1'b1};
      end else begin
        rem <= {rem[SIZE_W-2:0], dvd[ADDR_W-1]};
        dvd <= {dvd[ADDR_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  assign stat.alloc_full   = (used_blocks >= blocks) || (open_words == '0);
  assign stat.below_base   = (addr_q < base_address);
  assign stat.div_last     = &div_cnt;
  assign stat.out_of_range = (dvd >= ADDR_W'(blocks));
  assign stat.bit_set      = map_word[dvd[BIT_IDX_W-1:0]];

  // result register, shown for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status        <= cmd.emit_status;
      result.block_address <= cmd.emit_addr ? alloc_addr : '0;
      result.used_count    <= used_blocks;
    end
  end

endmodule
